/* sv/hpt_pkg.sv */
package hpt_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;

    localparam int FIELD_W  = 32;
    localparam int PROD_W   = 2 * COORD_WIDTH;
    localparam int SUM_W    = 2 * COORD_WIDTH + 2;
    localparam int MAG_W    = 2 * COORD_WIDTH;
    localparam int NCOEF    = 16;
    localparam int NPAIR    = 8;
    localparam int PAIR_W   = 3;
    localparam int PADDR_W  = 6;
    localparam int PDATA_W  = 64;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int DIV_LAT  = COORD_WIDTH + 2;
    localparam int BACK_LAT = 4 + DIV_LAT;

    localparam logic OP_POINT = 1'b0;
    localparam logic OP_DIR   = 1'b1;

    localparam logic [FIELD_W-1:0] OUT_MAX =
        FIELD_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic [FIELD_W-1:0] OUT_MIN = ~OUT_MAX;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef t_coord [NCOEF-1:0] t_matrix;

    typedef struct packed {
        logic   point;
        t_coord x;
        t_coord y;
        t_coord z;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

/* sv/hpt_queue.sv */
module hpt_queue
    import hpt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_item  i_wdata,
    input  logic   i_rd,
    output t_item  o_rdata,
    output t_qstat o_stat
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

/* sv/hpt_front.sv */
module hpt_front
    import hpt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_valid,
    input  logic                 i_s_user,
    input  logic [3*FIELD_W-1:0] i_s_data,
    output logic                 o_s_ready,
    input  logic                 i_pop,
    output t_item                o_item,
    output t_qstat               o_stat
);

    t_item  w_item;
    t_qstat w_stat;

    always_comb begin
        w_item.point = (i_s_user == OP_POINT);
        w_item.x     = i_s_data[0*FIELD_W +: COORD_WIDTH];
        w_item.y     = i_s_data[1*FIELD_W +: COORD_WIDTH];
        w_item.z     = i_s_data[2*FIELD_W +: COORD_WIDTH];
    end

    hpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_s_valid && !w_stat.full),
        .i_wdata (w_item),
        .i_rd    (i_pop),
        .o_rdata (o_item),
        .o_stat  (w_stat)
    );

    assign o_s_ready = !w_stat.full;
    assign o_stat    = w_stat;

endmodule

/* sv/hpt_divider.sv */
module hpt_divider
    import hpt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [MAG_W-1:0] i_nmag,
    input  logic             i_neg,
    input  logic [MAG_W-1:0] i_dmag,
    output t_coord           o_val,
    output logic             o_sat
);

    localparam int SH = COORD_WIDTH - FRAC_BITS;
    localparam logic [COORD_WIDTH-1:0] HALF = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [MAG_W-1:0]       r_rem  [COORD_WIDTH+1];
    logic [MAG_W-1:0]       r_d    [COORD_WIDTH+1];
    logic [COORD_WIDTH-1:0] r_nlow [COORD_WIDTH+1];
    logic [COORD_WIDTH-1:0] r_q    [COORD_WIDTH+1];
    logic                   r_big  [COORD_WIDTH+1];
    logic                   r_neg  [COORD_WIDTH+1];
    t_coord                 r_val;
    logic                   r_sat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_big[0]  <= ({{SH{1'b0}}, i_nmag} >= ({i_dmag, {SH{1'b0}}}));
            r_neg[0]  <= i_neg;
            r_d[0]    <= i_dmag;
            r_rem[0]  <= i_nmag >> SH;
            r_nlow[0] <= {i_nmag[SH-1:0], {FRAC_BITS{1'b0}}};
            r_q[0]    <= '0;
        end
    end

    for (genvar j = 0; j < COORD_WIDTH; j++) begin : g_stage
        logic [MAG_W:0] w_cat;
        logic [MAG_W:0] w_trial;
        always_comb begin
            w_cat   = {r_rem[j], r_nlow[j][COORD_WIDTH-1-j]};
            w_trial = w_cat - {1'b0, r_d[j]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= w_trial[MAG_W] ? w_cat[MAG_W-1:0] : w_trial[MAG_W-1:0];
                r_q[j+1]    <= {r_q[j][COORD_WIDTH-2:0], !w_trial[MAG_W]};
                r_d[j+1]    <= r_d[j];
                r_nlow[j+1] <= r_nlow[j];
                r_big[j+1]  <= r_big[j];
                r_neg[j+1]  <= r_neg[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[COORD_WIDTH]) begin
                if (r_big[COORD_WIDTH] || (r_q[COORD_WIDTH] > HALF)) begin
                    r_val <= HALF;
                    r_sat <= 1'b1;
                end else begin
                    r_val <= -r_q[COORD_WIDTH];
                    r_sat <= 1'b0;
                end
            end else begin
                if (r_big[COORD_WIDTH] || r_q[COORD_WIDTH][COORD_WIDTH-1]) begin
                    r_val <= ~HALF;
                    r_sat <= 1'b1;
                end else begin
                    r_val <= r_q[COORD_WIDTH];
                    r_sat <= 1'b0;
                end
            end
        end
    end

    assign o_val = r_val;
    assign o_sat = r_sat;

endmodule

/* sv/hpt_back.sv */
module hpt_back
    import hpt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_matrix            i_matrix,
    input  t_item              i_item,
    input  logic               i_avail,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [FIELD_W-1:0] o_x,
    output logic [FIELD_W-1:0] o_y,
    output logic [FIELD_W-1:0] o_z,
    output logic               o_wzero,
    output logic               o_sat
);

    logic                    w_adv;
    logic [BACK_LAT-1:0]     r_vld;
    logic signed [PROD_W-1:0] r_prod  [4][3];
    t_coord                   r_trans [4];
    logic signed [SUM_W-1:0]  r_pa    [4];
    logic signed [SUM_W-1:0]  r_pb    [4];
    logic signed [SUM_W-1:0]  r_sum   [4];
    logic [MAG_W-1:0]         r_nmag  [3];
    logic                     r_sneg  [3];
    logic [MAG_W-1:0]         r_dmag;
    logic [DIV_LAT:0]         r_wz;
    t_coord                   w_in    [3];
    logic [MAG_W-1:0]         n_mag   [4];
    logic                     n_neg   [4];
    logic signed [SUM_W-1:0]  w_negsum;
    logic                     n_wz;
    t_coord                   w_q     [3];
    logic                     w_sat   [3];

    assign w_adv = !r_vld[BACK_LAT-1] || i_ready;
    assign o_pop = w_adv && i_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[BACK_LAT-2:0], o_pop};
        end
    end

    always_comb begin
        w_in[0] = i_item.x;
        w_in[1] = i_item.y;
        w_in[2] = i_item.z;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < 4; c++) begin
                for (int i = 0; i < 3; i++) begin
                    r_prod[c][i] <= PROD_W'($signed(w_in[i]) * $signed(i_matrix[4*i+c]));
                end
                r_trans[c] <= i_item.point ? $signed(i_matrix[12+c]) : '0;
                r_pa[c]    <= SUM_W'(r_prod[c][0]) + SUM_W'(r_prod[c][1]);
                r_pb[c]    <= SUM_W'(r_prod[c][2]) + (SUM_W'(r_trans[c]) <<< FRAC_BITS);
                r_sum[c]   <= r_pa[c] + r_pb[c];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_negsum = -r_sum[c];
            n_neg[c] = r_sum[c][SUM_W-1];
            n_mag[c] = n_neg[c] ? w_negsum[MAG_W-1:0] : r_sum[c][MAG_W-1:0];
        end
        n_wz = (n_mag[3] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < 3; c++) begin
                r_nmag[c] <= n_mag[c];
                r_sneg[c] <= n_neg[c] ^ (n_neg[3] && !n_wz);
            end
            r_dmag <= n_wz ? (MAG_W'(1) << (2 * FRAC_BITS)) : n_mag[3];
            r_wz   <= {r_wz[DIV_LAT-1:0], n_wz};
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_div
        hpt_divider u_div (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_nmag (r_nmag[c]),
            .i_neg  (r_sneg[c]),
            .i_dmag (r_dmag),
            .o_val  (w_q[c]),
            .o_sat  (w_sat[c])
        );
    end

    assign o_valid = r_vld[BACK_LAT-1];
    assign o_x     = FIELD_W'($signed(w_q[0]));
    assign o_y     = FIELD_W'($signed(w_q[1]));
    assign o_z     = FIELD_W'($signed(w_q[2]));
    assign o_wzero = r_wz[DIV_LAT];
    assign o_sat   = w_sat[0] || w_sat[1] || w_sat[2];

endmodule

/* sv/homogeneous_point_transform_unit.sv */
// Transforms one point or direction per beat by the 4x4 matrix held in the eight
// 64-bit coefficient registers, then divides x, y and z by w (1.0 when w is zero).
// When the output is not stalled it takes a new beat every cycle; each result
// passes through the queue, the multiply-and-sum registers and the divider, which
// resolves one quotient bit per pipeline stage over 32 stages plus setup and
// clamping. Output stalls hold the whole back pipeline, and a four-entry queue
// accepts input beats meanwhile until it fills.
module homogeneous_point_transform_unit
    import hpt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [3*FIELD_W-1:0] s_axis_tdata,  // x_in, y_in, z_in
    input  logic                 s_axis_tuser,  // op
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [3*FIELD_W-1:0] m_axis_tdata,  // x_out, y_out, z_out
    output logic [1:0]           m_axis_tuser,  // w_was_zero, saturated
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    logic [PDATA_W-1:0] r_coef [NPAIR];
    t_matrix            w_matrix;
    t_item              w_item;
    t_qstat             w_qstat;
    logic               w_pop;
    logic [PAIR_W-1:0]  w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[PADDR_W-1 -: PAIR_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NPAIR; k++) begin
                r_coef[k] <= '0;
            end
            r_coef[0] <= PDATA_W'(1) << FRAC_BITS;
            r_coef[2] <= PDATA_W'(1) << (FRAC_BITS + 32);
            r_coef[5] <= PDATA_W'(1) << FRAC_BITS;
            r_coef[7] <= PDATA_W'(1) << (FRAC_BITS + 32);
        end else if (psel && penable && pwrite && pready) begin
            r_coef[w_idx] <= pwdata;
        end
    end

    assign prdata = r_coef[w_idx];

    always_comb begin
        for (int k = 0; k < NCOEF; k++) begin
            w_matrix[k] = r_coef[k/2][(k%2)*32 +: COORD_WIDTH];
        end
    end

    hpt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_user  (s_axis_tuser),
        .i_s_data  (s_axis_tdata),
        .o_s_ready (s_axis_tready),
        .i_pop     (w_pop),
        .o_item    (w_item),
        .o_stat    (w_qstat)
    );

    hpt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_matrix (w_matrix),
        .i_item   (w_item),
        .i_avail  (!w_qstat.empty),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_x      (m_axis_tdata[0*FIELD_W +: FIELD_W]),
        .o_y      (m_axis_tdata[1*FIELD_W +: FIELD_W]),
        .o_z      (m_axis_tdata[2*FIELD_W +: FIELD_W]),
        .o_wzero  (m_axis_tuser[0]),
        .o_sat    (m_axis_tuser[1])
    );

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(psel && penable && pwrite) && (paddr == $past(paddr))
        |-> (prdata == $past(pwdata)))
        else $error("register readback differs from last write");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1]
        |-> (m_axis_tdata[31:0] == OUT_MAX) || (m_axis_tdata[31:0] == OUT_MIN)
         || (m_axis_tdata[63:32] == OUT_MAX) || (m_axis_tdata[63:32] == OUT_MIN)
         || (m_axis_tdata[95:64] == OUT_MAX) || (m_axis_tdata[95:64] == OUT_MIN))
        else $error("saturation flagged without a clamped coordinate");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("queue popped while empty");

endmodule

/* tb/homogeneous_point_transform_unit_chk.sv */
module homogeneous_point_transform_unit_chk
    import hpt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [3*FIELD_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [3*FIELD_W-1:0] m_axis_tdata,
    input  logic [1:0]           m_axis_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    input  logic                 pready,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct {
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] z;
        logic               wzero;
        logic               sat;
    } t_proj;

    logic [PDATA_W-1:0] coef_regs [NPAIR];
    t_proj              proj_q [$];

    function automatic logic signed [COORD_WIDTH-1:0] mat_entry(input int k);
        logic [PDATA_W-1:0] p;
        p = coef_regs[k / 2];
        return (k % 2) ? p[63:32] : p[31:0];
    endfunction

    function automatic t_proj project(input logic op, input logic [3*FIELD_W-1:0] d);
        logic signed [127:0] v [3];
        logic signed [127:0] s [4];
        logic signed [127:0] w;
        logic signed [127:0] q;
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        t_proj r;
        v[0] = 128'(signed'(d[31:0]));
        v[1] = 128'(signed'(d[63:32]));
        v[2] = 128'(signed'(d[95:64]));
        hi = 128'sd2147483647;
        lo = -128'sd2147483648;
        for (int c = 0; c < 4; c++) begin
            s[c] = 0;
            for (int i = 0; i < 3; i++)
                s[c] += v[i] * 128'(mat_entry(4 * i + c));
            if (op == OP_POINT)
                s[c] += 128'(mat_entry(12 + c)) <<< FRAC_BITS;
        end
        w = s[3];
        r.wzero = (w == 0);
        if (r.wzero)
            w = 128'sd1 <<< (2 * FRAC_BITS);
        r.sat = 1'b0;
        for (int c = 0; c < 3; c++) begin
            q = (s[c] <<< FRAC_BITS) / w;
            if (q > hi) begin
                q = hi;
                r.sat = 1'b1;
            end else if (q < lo) begin
                q = lo;
                r.sat = 1'b1;
            end
            if (c == 0) r.x = q[31:0];
            else if (c == 1) r.y = q[31:0];
            else r.z = q[31:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_proj e;
        if (!i_rst_n) begin
            for (int i = 0; i < NPAIR; i++) coef_regs[i] = '0;
            coef_regs[0] = 64'd1 << FRAC_BITS;
            coef_regs[2] = 64'd1 << (32 + FRAC_BITS);
            coef_regs[5] = 64'd1 << FRAC_BITS;
            coef_regs[7] = 64'd1 << (32 + FRAC_BITS);
            proj_q.delete();
            o_fail_count = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (proj_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("Unexpected result beat %h", m_axis_tdata);
                end else begin
                    e = proj_q.pop_front();
                    if (m_axis_tdata !== {e.z, e.y, e.x} ||
                        m_axis_tuser !== {e.sat, e.wzero}) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("Mismatch: expected %h %h %h zw=%b sat=%b, got %h user=%b",
                                     e.x, e.y, e.z, e.wzero, e.sat, m_axis_tdata,
                                     m_axis_tuser);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                proj_q.push_back(project(s_axis_tuser, s_axis_tdata));
            if (psel && penable && pwrite && pready && paddr[5:3] < NPAIR)
                coef_regs[paddr[5:3]] = pwdata;
        end
        o_pending = proj_q.size();
    end

endmodule

/* tb/homogeneous_point_transform_unit_tb.sv */
module homogeneous_point_transform_unit_tb;
    import hpt_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [3*FIELD_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [3*FIELD_W-1:0] m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    int                   fail_count;
    int                   pending;
    int                   hold_off = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    homogeneous_point_transform_unit dut (.*);

    homogeneous_point_transform_unit_chk chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return $urandom;
            default: return 32'($signed($urandom_range(0, 20'hfffff)) - 32'sh80000);
        endcase
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 6))
            0: return 32'h0;
            1: return 32'h0001_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 20'h3ffff)) - 20'sh20000);
        endcase
    endfunction

    task automatic write_pair(input int idx, input logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(idx * 8);
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_beat(input logic op, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {z, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (BACK_LAT + 10) @(negedge i_clk);
    endtask

    always begin
        int stall;
        @(negedge i_clk);
        if (hold_off > 0) begin
            m_axis_tready <= 1'b0;
            repeat (hold_off) @(negedge i_clk);
            hold_off = 0;
        end
        stall = $urandom_range(0, 4);
        if (stall != 0 && $urandom_range(0, 3) != 0) begin
            m_axis_tready <= 1'b0;
            repeat (stall - 1) @(negedge i_clk);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        #5000000;
        $display("homogeneous_point_transform_unit_tb: FAIL");
        $finish;
    end

    initial begin
        logic [31:0] ext [4];
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
        // Identity matrix: extremes of every field and both operations.
        for (int i = 0; i < 4; i++) begin
            send_beat(OP_POINT, ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], 1'b0);
            send_beat(OP_DIR, ext[i], ext[(i + 3) % 4], ext[i], 1'b0);
        end
        send_beat(OP_POINT, 32'h0001_8000, 32'hfffe_8000, 32'h0000_0001, 1'b1);
        drain();
        // A w column zero but for a tiny y entry forces the divide-by-one path, and a tiny w saturates.
        write_pair(7, 64'h0000_0000_0001_0000);
        write_pair(3, 64'h0000_0001_0000_0000);
        send_beat(OP_POINT, 32'h0003_0000, 32'hfffd_4000, 32'h7fff_ffff, 1'b0);
        send_beat(OP_DIR, 32'h0003_0000, 32'h0, 32'h8000_0000, 1'b0);
        send_beat(OP_POINT, 32'h0, 32'h0, 32'h0, 1'b0);
        drain();
        write_pair(7, 64'hffff_ffff_0001_0000);
        send_beat(OP_POINT, 32'h0, 32'h0, 32'h0, 1'b0);
        send_beat(OP_POINT, 32'h0100_0000, 32'h0, 32'h0, 1'b0);
        send_beat(OP_DIR, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        drain();
        // Long output stall while the input keeps offering beats.
        hold_off = 120;
        for (int i = 0; i < 60; i++)
            send_beat(OP_POINT, pick_coord(), pick_coord(), pick_coord(), 1'b0);
        drain();
        for (int phase = 0; phase < 11; phase++) begin
            for (int k = 0; k < NPAIR; k++) begin
                if (phase == 9)
                    write_pair(k, 64'hffff_ffff_ffff_ffff);
                else if (phase == 10)
                    write_pair(k, 64'h7fff_ffff_8000_0000);
                else
                    write_pair(k, {pick_coef(), pick_coef()});
            end
            for (int i = 0; i < 43; i++)
                send_beat(logic'($urandom_range(0, 1)), pick_coord(), pick_coord(),
                          pick_coord(), $urandom_range(0, 3) != 0);
            drain();
        end
        if (fail_count == 0) begin
            $display("homogeneous_point_transform_unit_tb: PASS");
        end else begin
            $display("homogeneous_point_transform_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
